### sv/ssi_pkg.sv
// Shared constants and types for the point-to-segment squared distance block.
// No dependencies; imported by every module of the block.
`default_nettype none
package ssi_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int RADIUS_W          = 16;
  localparam int R2_W              = 2 * RADIUS_W;
  localparam int DIST_W            = 34;
  localparam int OUT_TDATA_W       = ((DIST_W + 1 + 7) / 8) * 8;
  localparam int OUT_TUSER_W       = 2;

  typedef enum logic [1:0] {
    CASE_START    = 2'd0,
    CASE_END      = 2'd1,
    CASE_INTERIOR = 2'd2
  } ncase_t;

endpackage
`default_nettype wire

### sv/ssi_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, sideband carried along.
// Depends on ssi_pkg.
`default_nettype none
module ssi_div_pipe #(
  parameter int LENW = 34,
  parameter int FB   = 16,
  parameter int SBW  = 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [LENW-1:0] in_dividend,
  input  wire logic [LENW-1:0] in_divisor,
  input  wire logic [SBW-1:0]  in_side,
  output logic                 out_valid,
  output logic [FB-1:0]        out_quot,
  output logic [SBW-1:0]       out_side
);
  import ssi_pkg::*;

  logic            valid_r [FB];
  logic [LENW-1:0] rem_r   [FB];
  logic [LENW-1:0] div_r   [FB];
  logic [FB-1:0]   quot_r  [FB];
  logic [SBW-1:0]  side_r  [FB];

  for (genvar k = 0; k < FB; k++) begin : g_stage
    logic            v_in;
    logic [LENW-1:0] rem_in;
    logic [LENW-1:0] div_in;
    logic [FB-1:0]   q_in;
    logic [SBW-1:0]  side_in;
    logic [LENW:0]   shl;
    logic [LENW:0]   diff;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_dividend;
      assign div_in  = in_divisor;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = valid_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign div_in  = div_r[k-1];
      assign q_in    = quot_r[k-1];
      assign side_in = side_r[k-1];
    end

    // remainder stays below the divisor, so the shifted value is below twice it
    assign shl  = {rem_in, 1'b0};
    assign diff = shl - {1'b0, div_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= v_in;
      end
      if (en) begin
        div_r[k]  <= div_in;
        side_r[k] <= side_in;
        if (shl >= {1'b0, div_in}) begin
          rem_r[k]  <= diff[LENW-1:0];
          quot_r[k] <= {q_in[FB-2:0], 1'b1};
        end else begin
          rem_r[k]  <= shl[LENW-1:0];
          quot_r[k] <= {q_in[FB-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = valid_r[FB-1];
  assign out_quot  = quot_r[FB-1];
  assign out_side  = side_r[FB-1];

endmodule
`default_nettype wire

### sv/sphere_segment_intersect_top.sv
// Throughput: one item per cycle; the pipeline advances as a whole whenever the
//   output register is empty or being drained, so a stall holds every stage.
// Depth is set by the divider, one quotient bit per stage.
// Reset (rst_n low, synchronous): all valid bits clear, radius squared clears to 0.
`default_nettype none
module sphere_segment_intersect_top #(
  parameter int COORD_WIDTH   = ssi_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = ssi_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // cfg: sphere_radius, unsigned Q16.0
  input  wire logic                                  cfg_wr_en,
  input  wire logic [ssi_pkg::RADIUS_W-1:0]          cfg_wdata,
  // in_tdata, from bit 0 up: point_x, point_y, point_z, seg_start_x, seg_start_y,
  //   seg_start_z, seg_end_x, seg_end_y, seg_end_z (each COORD_WIDTH), zero fill
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  // out_tdata, from bit 0 up: dist_sq (34), hit (1), zero fill
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [ssi_pkg::OUT_TDATA_W-1:0]            out_tdata,
  // out_tuser: nearest_case (2)
  output logic [ssi_pkg::OUT_TUSER_W-1:0]            out_tuser
);
  import ssi_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int DW   = CW + 1;          // coordinate difference
  localparam int PW   = 2 * DW;          // product of two differences
  localparam int DOTW = PW + 2;          // signed dot product
  localparam int LENW = PW;              // squared length and endpoint distances
  localparam int DDW  = DW + FB + 2;     // scaled offset to the interpolated point
  localparam int ML   = (DDW + 1) / 2;   // low half for the split square
  localparam int MH   = DDW - ML;
  localparam int SQW  = 2 * DDW;
  localparam int SUMW = SQW + 2;
  localparam int FDW  = SUMW - 2 * FB;   // interior distance, unsigned Q.0
  localparam int CMPW = (FDW > DIST_W) ? FDW : DIST_W;

  typedef struct packed {
    logic [2:0][DW-1:0] tp;
    logic [2:0][DW-1:0] ln;
    ncase_t             ncase;
    logic [LENW-1:0]    dsel;
  } side_t;

  localparam int SBW = $bits(side_t);

  // Global advance: the whole pipe moves when the output register can take an item.
  logic en;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Radius squared, formed on the config write.
  logic [R2_W-1:0] r2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r2_r <= '0;
    end else if (cfg_wr_en) begin
      r2_r <= R2_W'(cfg_wdata) * R2_W'(cfg_wdata);
    end
  end

  // Stage 1: differences S->P, S->E, E->P.
  logic                 s1_valid_r;
  logic signed [DW-1:0] s1_tp_r [3];
  logic signed [DW-1:0] s1_ln_r [3];
  logic signed [DW-1:0] s1_pe_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_tvalid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_tp_r[i] <= DW'($signed(in_tdata[i*CW +: CW])) - DW'($signed(in_tdata[(3+i)*CW +: CW]));
        s1_ln_r[i] <= DW'($signed(in_tdata[(6+i)*CW +: CW])) - DW'($signed(in_tdata[(3+i)*CW +: CW]));
        s1_pe_r[i] <= DW'($signed(in_tdata[i*CW +: CW])) - DW'($signed(in_tdata[(6+i)*CW +: CW]));
      end
    end
  end

  // Stage 2: per-axis products.
  logic                 s2_valid_r;
  logic signed [PW-1:0] s2_dotp_r [3];
  logic signed [PW-1:0] s2_lenp_r [3];
  logic signed [PW-1:0] s2_sp_r   [3];
  logic signed [PW-1:0] s2_ep_r   [3];
  logic signed [DW-1:0] s2_tp_r   [3];
  logic signed [DW-1:0] s2_ln_r   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dotp_r[i] <= s1_tp_r[i] * s1_ln_r[i];
        s2_lenp_r[i] <= s1_ln_r[i] * s1_ln_r[i];
        s2_sp_r[i]   <= s1_tp_r[i] * s1_tp_r[i];
        s2_ep_r[i]   <= s1_pe_r[i] * s1_pe_r[i];
        s2_tp_r[i]   <= s1_tp_r[i];
        s2_ln_r[i]   <= s1_ln_r[i];
      end
    end
  end

  // Stage 3: sums and the nearest-point decision.
  logic signed [DOTW-1:0] dot_c;
  logic [LENW-1:0]        len2_c;
  logic [LENW-1:0]        dstart_c;
  logic [LENW-1:0]        dend_c;
  ncase_t                 ncase_c;

  always_comb begin
    dot_c    = DOTW'(s2_dotp_r[0]) + DOTW'(s2_dotp_r[1]) + DOTW'(s2_dotp_r[2]);
    len2_c   = $unsigned(s2_lenp_r[0]) + $unsigned(s2_lenp_r[1]) + $unsigned(s2_lenp_r[2]);
    dstart_c = $unsigned(s2_sp_r[0]) + $unsigned(s2_sp_r[1]) + $unsigned(s2_sp_r[2]);
    dend_c   = $unsigned(s2_ep_r[0]) + $unsigned(s2_ep_r[1]) + $unsigned(s2_ep_r[2]);
    if (dot_c <= 0) begin
      ncase_c = CASE_START;
    end else if ($signed({2'b00, len2_c}) <= dot_c) begin
      ncase_c = CASE_END;
    end else begin
      ncase_c = CASE_INTERIOR;
    end
  end

  logic            s3_valid_r;
  logic [LENW-1:0] s3_dividend_r;
  logic [LENW-1:0] s3_len2_r;
  side_t           s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s3_valid_r <= s2_valid_r;
    end
    if (en) begin
      // feed zero outside the interior case so the divider never overflows
      s3_dividend_r   <= (ncase_c == CASE_INTERIOR) ? dot_c[LENW-1:0] : '0;
      s3_len2_r       <= len2_c;
      s3_side_r.ncase <= ncase_c;
      s3_side_r.dsel  <= (ncase_c == CASE_START) ? dstart_c : dend_c;
      for (int i = 0; i < 3; i++) begin
        s3_side_r.tp[i] <= s2_tp_r[i];
        s3_side_r.ln[i] <= s2_ln_r[i];
      end
    end
  end

  // Fraction t = dot / len2, FB fraction bits.
  logic           dv_valid;
  logic [FB-1:0]  dv_quot;
  logic [SBW-1:0] dv_side_bits;
  side_t          dv_side;

  ssi_div_pipe #(
    .LENW (LENW),
    .FB   (FB),
    .SBW  (SBW)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (s3_valid_r),
    .in_dividend (s3_dividend_r),
    .in_divisor  (s3_len2_r),
    .in_side     (s3_side_r),
    .out_valid   (dv_valid),
    .out_quot    (dv_quot),
    .out_side    (dv_side_bits)
  );

  assign dv_side = side_t'(dv_side_bits);

  // D1: scaled offset d = tp * 2^FB - t * ln, magnitude.
  logic signed [DDW-1:0] dd_c [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_c[i] = (DDW'($signed(dv_side.tp[i])) <<< FB)
                - $signed({1'b0, dv_quot}) * DDW'($signed(dv_side.ln[i]));
    end
  end

  logic            d1_valid_r;
  logic [DDW-1:0]  d1_m_r [3];
  ncase_t          d1_ncase_r;
  logic [LENW-1:0] d1_dsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_valid_r <= 1'b0;
    end else if (en) begin
      d1_valid_r <= dv_valid;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_m_r[i] <= (dd_c[i] < 0) ? $unsigned(-dd_c[i]) : $unsigned(dd_c[i]);
      end
      d1_ncase_r <= dv_side.ncase;
      d1_dsel_r  <= dv_side.dsel;
    end
  end

  // D2: split square into three narrow partial products.
  logic               d2_valid_r;
  logic [2*MH-1:0]    d2_hh_r [3];
  logic [MH+ML-1:0]   d2_hl_r [3];
  logic [2*ML-1:0]    d2_ll_r [3];
  ncase_t             d2_ncase_r;
  logic [LENW-1:0]    d2_dsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_valid_r <= 1'b0;
    end else if (en) begin
      d2_valid_r <= d1_valid_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d2_hh_r[i] <= (2*MH)'(d1_m_r[i][DDW-1:ML]) * (2*MH)'(d1_m_r[i][DDW-1:ML]);
        d2_hl_r[i] <= (MH+ML)'(d1_m_r[i][DDW-1:ML]) * (MH+ML)'(d1_m_r[i][ML-1:0]);
        d2_ll_r[i] <= (2*ML)'(d1_m_r[i][ML-1:0]) * (2*ML)'(d1_m_r[i][ML-1:0]);
      end
      d2_ncase_r <= d1_ncase_r;
      d2_dsel_r  <= d1_dsel_r;
    end
  end

  // D3: recombine per-axis squares.
  logic            d3_valid_r;
  logic [SQW-1:0]  d3_sq_r [3];
  ncase_t          d3_ncase_r;
  logic [LENW-1:0] d3_dsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d3_valid_r <= 1'b0;
    end else if (en) begin
      d3_valid_r <= d2_valid_r;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d3_sq_r[i] <= (SQW'(d2_hh_r[i]) << (2*ML)) + (SQW'(d2_hl_r[i]) << (ML+1))
                      + SQW'(d2_ll_r[i]);
      end
      d3_ncase_r <= d2_ncase_r;
      d3_dsel_r  <= d2_dsel_r;
    end
  end

  // D4: sum the axes and drop the fraction bits of t squared.
  logic [SUMW-1:0] sum_c;
  assign sum_c = SUMW'(d3_sq_r[0]) + SUMW'(d3_sq_r[1]) + SUMW'(d3_sq_r[2]);

  logic            d4_valid_r;
  logic [FDW-1:0]  d4_int_r;
  ncase_t          d4_ncase_r;
  logic [LENW-1:0] d4_dsel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d4_valid_r <= 1'b0;
    end else if (en) begin
      d4_valid_r <= d3_valid_r;
    end
    if (en) begin
      d4_int_r   <= sum_c[SUMW-1:2*FB];
      d4_ncase_r <= d3_ncase_r;
      d4_dsel_r  <= d3_dsel_r;
    end
  end

  // Output register: select the distance, compare on the full value, then mask.
  logic [CMPW-1:0] full_c;
  assign full_c = (d4_ncase_r == CASE_INTERIOR) ? CMPW'(d4_int_r) : CMPW'(d4_dsel_r);

  logic              out_valid_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_hit_r;
  ncase_t            out_case_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d4_valid_r;
    end
    if (en) begin
      out_dist_r <= full_c[DIST_W-1:0];
      out_hit_r  <= (full_c <= CMPW'(r2_r));
      out_case_r <= d4_ncase_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DIST_W-1){1'b0}}, out_hit_r, out_dist_r};
  assign out_tuser  = out_case_r;

endmodule
`default_nettype wire

### sv/ssi_checker.sv
// Port-level checks for the point-to-segment distance block, bound to the top level.
// Depends on ssi_pkg and sphere_segment_intersect_top.
`default_nettype none
module ssi_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [ssi_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input wire logic [ssi_pkg::OUT_TUSER_W-1:0]     out_tuser
);
  import ssi_pkg::*;

  // A stalled result holds its item.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // Input side advances exactly when the output register can drain.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output drain");

  // Reset empties the pipe.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sphere_segment_intersect_top ssi_checker u_ssi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

### bench/tb_top.sv
// Testbench for sphere_segment_intersect_top: point-to-segment squared distance
// with sphere hit flag. Predicts each result from the item and the radius setting.
// Depends on ssi_pkg and the block's RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssi_pkg::*;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int IN_W = ((9 * CW + 7) / 8) * 8;
  localparam int LATENCY = FB + 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [DIST_W-1:0] dist_sq;
    logic              hit;
    ncase_t            nearest_case;
  } seg_result_t;

  // Hold the pending distance results and check them in order.
  class dist_scoreboard;
    seg_result_t pending[$];
    logic [RADIUS_W-1:0] radius;
    int errors;

    function new();
      radius = '0;
      errors = 0;
    endfunction

    // Work out the expected result of one query and queue it.
    function void note_query(logic [IN_W-1:0] item);
      longint p[3], s[3], e[3], ln[3], tp[3];
      longint dot, len2, rem, t, d;
      logic [127:0] acc, dist_full, r2;
      seg_result_t res;
      int i;
      dot = 0;
      len2 = 0;
      acc = '0;
      for (i = 0; i < 3; i++) begin
        p[i] = longint'($signed(item[i*CW +: CW]));
        s[i] = longint'($signed(item[(3+i)*CW +: CW]));
        e[i] = longint'($signed(item[(6+i)*CW +: CW]));
        ln[i] = e[i] - s[i];
        tp[i] = p[i] - s[i];
        dot += tp[i] * ln[i];
        len2 += ln[i] * ln[i];
      end
      if (dot <= 0) begin
        res.nearest_case = CASE_START;
        for (i = 0; i < 3; i++) acc += 128'(tp[i] * tp[i]);
        dist_full = acc;
      end else if (len2 <= dot) begin
        res.nearest_case = CASE_END;
        for (i = 0; i < 3; i++) acc += 128'((p[i] - e[i]) * (p[i] - e[i]));
        dist_full = acc;
      end else begin
        res.nearest_case = CASE_INTERIOR;
        rem = dot;
        t = 0;
        // Restoring division: one quotient bit per step.
        for (i = 0; i < FB; i++) begin
          rem = rem <<< 1;
          t = t <<< 1;
          if (rem >= len2) begin
            rem -= len2;
            t |= 1;
          end
        end
        for (i = 0; i < 3; i++) begin
          d = (tp[i] <<< FB) - t * ln[i];
          if (d < 0) d = -d;
          acc += 128'(d) * 128'(d);
        end
        dist_full = acc >> (2 * FB);
      end
      r2 = 128'(radius) * 128'(radius);
      res.dist_sq = dist_full[DIST_W-1:0];
      res.hit = (dist_full <= r2);
      pending.push_back(res);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
      seg_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: dist_sq %0d", data[DIST_W-1:0]);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[DIST_W-1:0] !== want.dist_sq) begin
        $error("dist_sq: expected %0d actual %0d", want.dist_sq, data[DIST_W-1:0]);
        errors++;
      end
      if (data[DIST_W] !== want.hit) begin
        $error("hit: expected %0d actual %0d", want.hit, data[DIST_W]);
        errors++;
      end
      if (user !== want.nearest_case) begin
        $error("nearest_case: expected %0d actual %0d", want.nearest_case, user);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [RADIUS_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  dist_scoreboard sb = new();
  int idle_pct = 20;    // idle chance per side, percent
  int stall_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  sphere_segment_intersect_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // Sample results at the rising edge; count cycles with no handshake.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // Stall the result side at random, changing at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Stop the run if nothing moves for too long.
  always @(posedge clk) begin
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Present one query and hold it until accepted; note it on acceptance.
  // Valid stays high on return so the next item can follow with no gap.
  task automatic send_query(logic [IN_W-1:0] item);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= item;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_query(item);
    @(negedge clk);
  endtask

  function automatic logic [IN_W-1:0] pack_query(int px, py, pz,
                                                 sx, sy, sz, ex, ey, ez);
    return {CW'(ez), CW'(ey), CW'(ex), CW'(sz), CW'(sy), CW'(sx),
            CW'(pz), CW'(py), CW'(px)};
  endfunction

  function automatic logic [CW-1:0] rand_coord(int spread);
    case (spread)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(512)) - 256);
      default: return CW'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  // Build a random query; mostly segments near the point so all cases occur.
  function automatic logic [IN_W-1:0] rand_query();
    logic [CW-1:0] c[9];
    int spread;
    int k;
    spread = $urandom_range(2);
    for (k = 0; k < 9; k++) c[k] = rand_coord(spread);
    if ($urandom_range(9) == 0) begin
      c[6] = c[3]; c[7] = c[4]; c[8] = c[5];  // zero-length segment
    end
    return {c[8], c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
  endfunction

  // Drop valid, drain outstanding results, then let the pipeline settle.
  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_radius(logic [RADIUS_W-1:0] r);
    cfg_wr_en <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.radius = r;
  endtask

  localparam int CMAX = 32767;
  localparam int CMIN = -32768;

  initial begin
    logic [RADIUS_W-1:0] radii[6];
    int ph;
    int n;
    radii = '{16'hffff, 16'h0040, 16'h1000, 16'h0001, 16'h0800, 16'h0000};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_radius(16'h0000);

    // Directed: extremes, each nearest-point case, zero-length segment.
    send_query(pack_query(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(pack_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
    send_query(pack_query(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
    send_query(pack_query(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_query(pack_query(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN));
    send_query(pack_query(16, 16, 0, 0, 0, 0, 32, 0, 0));     // interior
    send_query(pack_query(-16, 5, 0, 0, 0, 0, 32, 0, 0));     // before start
    send_query(pack_query(48, 5, 0, 0, 0, 0, 32, 0, 0));      // past end
    send_query(pack_query(32, 7, 3, 0, 0, 0, 32, 0, 0));      // dot equals length
    send_query(pack_query(5, 6, 7, 9, 9, 9, 9, 9, 9));        // zero length
    send_query(pack_query(1, 0, 0, 0, 0, 0, 3, 0, 0));        // fraction 1/3
    send_query(pack_query(CMAX, 0, 0, CMIN, 0, 0, CMAX, 1, 0));
    send_query(pack_query(0, CMAX, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
    send_query(pack_query(-1, -1, -1, 0, 0, 0, 'h5555, 'haaaa, 1));

    // Random phases, each with its own radius; one phase runs without idling.
    for (ph = 0; ph < 6; ph++) begin
      drain_pipe();
      write_radius(radii[ph]);
      idle_pct = (ph == 2) ? 0 : 20;
      for (n = 0; n < 140; n++) send_query(rand_query());
    end
    idle_pct = 20;

    drain_pipe();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
